// ===== src/bmpu_pkg.sv =====
`default_nettype none

package bmpu_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int ENTRY_W       = 32;

    typedef enum logic [1:0] {
        FMT_1BPP  = 2'd0,
        FMT_4BPP  = 2'd1,
        FMT_8BPP  = 2'd2,
        FMT_24BPP = 2'd3
    } t_fmt;

    typedef enum logic {
        FUNC_PAL_WR = 1'b0,
        FUNC_DATA   = 1'b1
    } t_func;

    typedef struct packed {
        logic       last;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

endpackage

`default_nettype wire

// ===== src/bmp_palette_pixel_unpacker.sv =====
// Bitmap pixel-data unpacker with a 256-entry RGBA palette.
// Input stream (s_axis): tuser selects palette write or pixel data byte; tdata
// carries palette index, entry colors, data byte and the chunk-start flag.
// Output stream (m_axis): one RGBA pixel per item, tlast on the final pixel
// caused by one data byte. Config channel: pixel format, to be written only
// while idle; the block does not enforce this. Each pixel passes the palette
// read and pixel stage into the output queue. Throughput is set by the single
// palette read port, one pixel per cycle while the queue has credit: a 1 bpp
// byte yields 8 pixels, 4 bpp 2, 8 bpp 1; a palette write and every 24 bpp
// byte take a single step. A two-entry output queue with credit accounting
// lets the next pixel issue while the previous one waits; when m_axis stalls,
// pixel issue stops; s_axis_tready drops once the current byte cannot finish.
// Reset clears the format (1 bpp), the 24 bpp byte phase and held bytes, and
// empties the pipeline. Palette contents are undefined until written.
`default_nettype none

module bmp_palette_pixel_unpacker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // cfg data: pixel_format[1:0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // palette_index[7:0], pal_red[15:8], pal_green[23:16], pal_blue[31:24],
    // pal_alpha[39:32], data_byte[47:40], chunk_start[48], zero[55:49]
    input  wire logic [55:0] s_axis_tdata,
    // func[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    bmpu_pkg::t_fmt  r_fmt;
    logic            r_busy;
    bmpu_pkg::t_func r_func;
    logic [7:0]      r_idx;
    logic [31:0]     r_ent;
    logic [7:0]      r_byte;
    logic            r_cs;
    logic [2:0]      r_cnt;
    logic [1:0]      r_phase;
    logic [15:0]     r_held;

    logic            r_p1_vld;
    logic            r_p1_direct;
    logic            r_p1_zero;
    bmpu_pkg::t_pix  r_p1_pix;

    bmpu_pkg::t_pix  r_q0;
    bmpu_pkg::t_pix  r_q1;
    logic [1:0]      r_occ;
    logic [1:0]      n_occ;

    logic            w_is_wr;
    logic [1:0]      w_phase;
    logic            w_need_out;
    logic            w_seq_last;
    logic [7:0]      w_rd_idx;
    logic [1:0]      w_load;
    logic            w_credit;
    logic            w_step;
    logic            w_done;
    logic            w_issue;
    logic            w_pop;
    logic            w_accept;
    logic            w_we;
    logic [31:0]     w_rdata;
    bmpu_pkg::t_pix  w_new;

    assign o_cfg_ready = 1'b1;

    assign w_is_wr = (r_func == bmpu_pkg::FUNC_PAL_WR);
    assign w_phase = r_cs ? 2'd0 : r_phase;

    always_comb begin
        w_need_out = 1'b1;
        w_seq_last = 1'b1;
        w_rd_idx   = r_byte;
        unique case (r_fmt)
            bmpu_pkg::FMT_1BPP: begin
                w_rd_idx   = {7'd0, r_byte[r_cnt]};
                w_seq_last = (r_cnt == 3'd7);
            end
            bmpu_pkg::FMT_4BPP: begin
                w_rd_idx   = {4'd0, (r_cnt[0] ? r_byte[7:4] : r_byte[3:0])};
                w_seq_last = r_cnt[0];
            end
            bmpu_pkg::FMT_8BPP: begin
                w_rd_idx   = r_byte;
            end
            bmpu_pkg::FMT_24BPP: begin
                w_need_out = (w_phase >= 2'd2);
            end
            default: begin
                w_rd_idx = r_byte;
            end
        endcase
    end

    assign w_pop    = (r_occ != 2'd0) && m_axis_tready;
    assign w_load   = r_occ + 2'(r_p1_vld) - 2'(w_pop);
    assign w_credit = (w_load < 2'd2);
    assign w_step   = r_busy && (w_is_wr || !w_need_out || w_credit);
    assign w_done   = w_step && (w_is_wr || w_seq_last);
    assign w_issue  = w_step && !w_is_wr && w_need_out;

    assign s_axis_tready = !r_busy || w_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_we = w_step && w_is_wr && (9'(r_idx) < 9'(bmpu_pkg::PALETTE_DEPTH));

    bmpu_ram #(
        .WIDTH(bmpu_pkg::ENTRY_W),
        .DEPTH(bmpu_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx[bmpu_pkg::PAL_AW-1:0]),
        .i_wdata(r_ent),
        .i_re   (w_issue),
        .i_raddr(w_rd_idx[bmpu_pkg::PAL_AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= bmpu_pkg::FMT_1BPP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fmt <= bmpu_pkg::t_fmt'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= bmpu_pkg::t_func'(s_axis_tuser);
            r_idx  <= s_axis_tdata[7:0];
            r_ent  <= {s_axis_tdata[39:32], s_axis_tdata[31:24],
                       s_axis_tdata[23:16], s_axis_tdata[15:8]};
            r_byte <= s_axis_tdata[47:40];
            r_cs   <= s_axis_tdata[48];
            r_cnt  <= 3'd0;
        end else if (w_step) begin
            r_cnt  <= r_cnt + 3'd1;
        end
    end

    // 24 bpp byte assembly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_held  <= 16'd0;
        end else if (w_step && !w_is_wr && (r_fmt == bmpu_pkg::FMT_24BPP)) begin
            if (w_phase == 2'd0) begin
                r_held  <= {8'd0, r_byte};
                r_phase <= 2'd1;
            end else if (w_phase == 2'd1) begin
                r_held  <= {r_byte, r_held[7:0]};
                r_phase <= 2'd2;
            end else begin
                r_phase <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_p1_direct    <= (r_fmt == bmpu_pkg::FMT_24BPP);
            r_p1_zero      <= (9'(w_rd_idx) >= 9'(bmpu_pkg::PALETTE_DEPTH));
            r_p1_pix.last  <= w_seq_last;
            r_p1_pix.alpha <= 8'd0;
            r_p1_pix.blue  <= r_held[7:0];
            r_p1_pix.green <= r_held[15:8];
            r_p1_pix.red   <= r_byte;
        end
    end

    always_comb begin
        if (r_p1_direct) begin
            w_new = r_p1_pix;
        end else if (r_p1_zero) begin
            w_new = {r_p1_pix.last, 32'd0};
        end else begin
            w_new = {r_p1_pix.last, w_rdata};
        end
    end

    assign n_occ = r_occ + 2'(r_p1_vld) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 2'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_occ == 2'd2) begin
                r_q0 <= r_q1;
                if (r_p1_vld) begin
                    r_q1 <= w_new;
                end
            end else if (r_p1_vld) begin
                r_q0 <= w_new;
            end
        end else if (r_p1_vld) begin
            if (r_occ == 2'd0) begin
                r_q0 <= w_new;
            end else begin
                r_q1 <= w_new;
            end
        end
    end

    assign m_axis_tvalid = (r_occ != 2'd0);
    assign m_axis_tdata  = {r_q0.alpha, r_q0.blue, r_q0.green, r_q0.red};
    assign m_axis_tlast  = r_q0.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == 2'd2 && r_p1_vld) |-> m_axis_tready)
        else $error("output queue overflow");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ != 2'd3)
        else $error("output queue count out of range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("24 bpp phase out of range");

    a_wr_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_is_wr) |=> !r_p1_vld)
        else $error("palette write produced a pixel");

    a_pal_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && r_fmt == bmpu_pkg::FMT_1BPP && r_cnt == 3'd7) |-> w_done)
        else $error("1 bpp byte not finished on eighth pixel");
`endif

endmodule

`default_nettype wire

// ===== src/bmpu_ram.sv =====
`default_nettype none

module bmpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 15;
    localparam int NUM_PHASES  = 9;

    typedef struct {
        bmpu_pkg::t_func func;
        logic [7:0]      idx;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
        logic [7:0]      data;
        logic            cs;
    } t_item;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data     = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    bmp_palette_pixel_unpacker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // stimulus side
    t_item           pending_items [$];
    t_item           inflight_item;
    logic            s_took        = 1'b0;
    int              snd_idle_pct  = 0;
    int              rcv_stall_pct = 0;
    logic            hold_start    = 1'b0;
    int              hold_left     = 0;
    int              cycle_count   = 0;
    int              err_count     = 0;
    bmpu_pkg::t_fmt  gen_fmt       = bmpu_pkg::FMT_1BPP;
    logic [255:0]    gen_written   = '0;

    // predicted block state
    logic [31:0]     pal_model [bmpu_pkg::PALETTE_DEPTH];
    bmpu_pkg::t_fmt  fmt_model     = bmpu_pkg::FMT_1BPP;
    logic [1:0]      phase_model   = '0;
    logic [15:0]     held_model    = '0;
    bmpu_pkg::t_pix  pix_expected [$];

    bmpu_pkg::t_fmt fmt_seq [NUM_PHASES] = '{
        bmpu_pkg::FMT_8BPP, bmpu_pkg::FMT_24BPP, bmpu_pkg::FMT_1BPP,
        bmpu_pkg::FMT_4BPP, bmpu_pkg::FMT_24BPP, bmpu_pkg::FMT_8BPP,
        bmpu_pkg::FMT_1BPP, bmpu_pkg::FMT_24BPP, bmpu_pkg::FMT_4BPP};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_fault(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    task automatic push_palette_pixel(input logic [7:0] idx, input logic last);
        bmpu_pkg::t_pix px;
        logic [31:0] e;
        e = pal_model[idx];
        px.red   = e[7:0];
        px.green = e[15:8];
        px.blue  = e[23:16];
        px.alpha = e[31:24];
        px.last  = last;
        pix_expected.push_back(px);
    endtask

    task automatic predict_pixels(input t_item it);
        bmpu_pkg::t_pix px;
        if (it.func == bmpu_pkg::FUNC_PAL_WR) begin
            pal_model[it.idx] = {it.alpha, it.blue, it.green, it.red};
            return;
        end
        case (fmt_model)
            bmpu_pkg::FMT_1BPP: begin
                for (int k = 0; k < 8; k++)
                    push_palette_pixel({7'd0, it.data[k]}, k == 7);
            end
            bmpu_pkg::FMT_4BPP: begin
                push_palette_pixel({4'd0, it.data[3:0]}, 1'b0);
                push_palette_pixel({4'd0, it.data[7:4]}, 1'b1);
            end
            bmpu_pkg::FMT_8BPP: begin
                push_palette_pixel(it.data, 1'b1);
            end
            default: begin
                if (it.cs)
                    phase_model = 2'd0;
                if (phase_model == 2'd0) begin
                    held_model  = {8'd0, it.data};
                    phase_model = 2'd1;
                end else if (phase_model == 2'd1) begin
                    held_model[15:8] = it.data;
                    phase_model      = 2'd2;
                end else begin
                    px.red   = it.data;
                    px.green = held_model[15:8];
                    px.blue  = held_model[7:0];
                    px.alpha = 8'd0;
                    px.last  = 1'b1;
                    pix_expected.push_back(px);
                    phase_model = 2'd0;
                end
            end
        endcase
    endtask

    task automatic check_pixel();
        bmpu_pkg::t_pix want;
        if (pix_expected.size() == 0) begin
            report_fault($sformatf("unexpected pixel data=%h last=%b",
                                   m_axis_tdata, m_axis_tlast));
            return;
        end
        want = pix_expected.pop_front();
        if (m_axis_tdata[7:0] !== want.red || m_axis_tdata[15:8] !== want.green ||
            m_axis_tdata[23:16] !== want.blue || m_axis_tdata[31:24] !== want.alpha ||
            m_axis_tlast !== want.last)
            report_fault($sformatf(
                "pixel mismatch: exp r=%h g=%h b=%h a=%h l=%b got r=%h g=%h b=%h a=%h l=%b",
                want.red, want.green, want.blue, want.alpha, want.last,
                m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                m_axis_tdata[31:24], m_axis_tlast));
    endtask

    // monitor: predict on accepted items, check accepted pixels
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
        s_took <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                fmt_model = bmpu_pkg::t_fmt'(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_pixels(inflight_item);
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
        end
    end

    // long receiver hold, counted in cycles
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // driver
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                it = pending_items.pop_front();
                inflight_item <= it;
                s_axis_tdata  <= {7'd0, it.cs, it.data, it.alpha, it.blue, it.green,
                                  it.red, it.idx};
                s_axis_tuser  <= it.func;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic gen_pal(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
        t_item it;
        it.func  = bmpu_pkg::FUNC_PAL_WR;
        it.idx   = idx;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.alpha = a;
        it.data  = 8'($urandom_range(255));
        it.cs    = 1'($urandom_range(1));
        pending_items.push_back(it);
        gen_written[idx] = 1'b1;
    endtask

    task automatic gen_pal_rand(input logic [7:0] idx);
        gen_pal(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic need_entry(input logic [7:0] idx);
        if (!gen_written[idx])
            gen_pal_rand(idx);
    endtask

    task automatic gen_data(input logic [7:0] b, input logic cs);
        t_item it;
        case (gen_fmt)
            bmpu_pkg::FMT_1BPP: begin
                need_entry(8'd0);
                need_entry(8'd1);
            end
            bmpu_pkg::FMT_4BPP: begin
                need_entry({4'd0, b[3:0]});
                need_entry({4'd0, b[7:4]});
            end
            bmpu_pkg::FMT_8BPP: need_entry(b);
            default: ;
        endcase
        it.func  = bmpu_pkg::FUNC_DATA;
        it.idx   = 8'($urandom_range(255));
        it.red   = 8'($urandom_range(255));
        it.green = 8'($urandom_range(255));
        it.blue  = 8'($urandom_range(255));
        it.alpha = 8'($urandom_range(255));
        it.data  = b;
        it.cs    = cs;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || pix_expected.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_format(input bmpu_pkg::t_fmt f);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= f;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_fmt = f;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 71; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 71; end
            default: begin snd_idle_pct = 20; rcv_stall_pct = 20; end
        endcase
    endtask

    initial begin
        logic cs;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(3);
        gen_pal(8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        gen_pal(8'd1, 8'hff, 8'hff, 8'hff, 8'hff);
        gen_data(8'h00, 1'b0);
        gen_data(8'hff, 1'b0);
        gen_data(8'ha5, 1'b1);

        set_format(bmpu_pkg::FMT_4BPP);
        gen_pal(8'd15, 8'h12, 8'h34, 8'h56, 8'h78);
        gen_data(8'h0f, 1'b0);
        gen_data(8'hf0, 1'b1);

        set_format(bmpu_pkg::FMT_8BPP);
        gen_pal(8'd255, 8'hff, 8'h00, 8'hff, 8'h00);
        gen_data(8'hff, 1'b0);
        gen_data(8'h00, 1'b1);
        gen_data(8'h01, 1'b0);

        // 24 bpp: complete pixel, palette write mid-pixel, restart dropping a partial
        set_format(bmpu_pkg::FMT_24BPP);
        gen_data(8'h00, 1'b1);
        gen_data(8'hff, 1'b0);
        gen_pal(8'h80, 8'h9a, 8'hbc, 8'hde, 8'hf0);
        gen_data(8'h80, 1'b0);
        gen_data(8'h12, 1'b0);
        gen_data(8'h34, 1'b0);
        gen_data(8'hab, 1'b1);
        gen_data(8'hcd, 1'b0);
        gen_data(8'hef, 1'b0);
        gen_data(8'h55, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_format(fmt_seq[p]);
            set_idling(p % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 20) begin
                    gen_pal_rand(8'($urandom_range(255)));
                end else begin
                    if (gen_fmt == bmpu_pkg::FMT_24BPP)
                        cs = ($urandom_range(99) < 8);
                    else
                        cs = 1'($urandom_range(1));
                    gen_data(8'($urandom_range(255)), cs);
                end
            end
        end

        // hold off the output while the input keeps offering 1 bpp bytes
        set_format(bmpu_pkg::FMT_1BPP);
        set_idling(0);
        @(negedge i_clk);
        hold_start <= 1'b1;
        @(negedge i_clk);
        hold_start <= 1'b0;
        for (int n = 0; n < 20; n++)
            gen_data(8'($urandom_range(255)), 1'($urandom_range(1)));

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pix_expected.size() != 0)
            report_fault($sformatf("%0d pixels never arrived", pix_expected.size()));
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
